>>> sv/refill_valve_controller_assert.svh
// Assertion macros for the refill valve controller.
// Expects signals named clk and arst_n in the scope where the macros are used.
`ifndef REFILL_VALVE_CONTROLLER_ASSERT_SVH
`define REFILL_VALVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RVC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rvc_pkg.sv
// Shared types and constants of the refill valve controller.
// No dependencies; used by rvc_next and refill_valve_controller.
`timescale 1ns / 1ps

package rvc_pkg;

	localparam int TimeW = 32;
	localparam int CfgW  = 24;
	localparam int IdxW  = 2;

	typedef enum logic [2:0] {
		MODE_UNKNOWN  = 3'd0,
		MODE_STARTING = 3'd1,
		MODE_IDLE     = 3'd2,
		MODE_ACTIVE   = 3'd3,
		MODE_ERROR    = 3'd4
	} mode_t;

	typedef enum logic {
		OP_SCAN   = 1'b0,
		OP_REINIT = 1'b1
	} opcode_t;

	localparam logic [IdxW-1:0] CFG_START_DELAY    = 2'd0;
	localparam logic [IdxW-1:0] CFG_LOW_HOLD_TIME  = 2'd1;
	localparam logic [IdxW-1:0] CFG_OK_HOLD_TIME   = 2'd2;
	localparam logic [IdxW-1:0] CFG_REFILL_TIMEOUT = 2'd3;

	localparam logic [CfgW-1:0] START_DELAY_RST    = 24'd0;
	localparam logic [CfgW-1:0] LOW_HOLD_TIME_RST  = 24'd500;
	localparam logic [CfgW-1:0] OK_HOLD_TIME_RST   = 24'd500;
	localparam logic [CfgW-1:0] REFILL_TIMEOUT_RST = 24'd60000;

	typedef struct packed {
		logic [CfgW-1:0] start_delay;
		logic [CfgW-1:0] low_hold_time;
		logic [CfgW-1:0] ok_hold_time;
		logic [CfgW-1:0] refill_timeout;
	} cfg_t;

	typedef struct packed {
		mode_t            mode;
		logic [TimeW-1:0] entered_at;
		logic [TimeW-1:0] stable_since;
	} state_t;

endpackage

>>> sv/refill_valve_controller.sv
// Refill valve controller: one scan or reinit item per clock unless the result stalls, one result item back for each.
// An item is accepted on s_tvalid && s_tready; the next state is computed in a single
// combinational pass (rvc_next) and lands in the state registers and the result register
// at that edge, so its result is offered on m_tvalid in the following cycle. One item is taken
// every clock; s_tready falls only while the result register holds an item that m_tready
// is not taking. Configuration writes on cfg_we take effect on the next item.
// Depends on rvc_pkg, rvc_next and refill_valve_controller_assert.svh.
`timescale 1ns / 1ps
`include "refill_valve_controller_assert.svh"

module refill_valve_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [39:0]               s_tdata,  // [31:0] now_ms, [32] level_ok, [33] fault_in
	input  logic                      s_tuser,  // [0] opcode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,  // [2:0] refill_mode, [3] mode_changed
	input  logic                      cfg_we,
	input  logic [rvc_pkg::IdxW-1:0]  cfg_index,
	input  logic [rvc_pkg::CfgW-1:0]  cfg_data
);

	rvc_pkg::cfg_t    cfg_q;
	rvc_pkg::state_t  state_q;
	rvc_pkg::state_t  state_nxt;
	rvc_pkg::mode_t   out_mode_q;
	rvc_pkg::opcode_t in_opcode;
	logic             out_changed_q;
	logic             out_valid_q;
	logic             changed;
	logic             accept;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign in_opcode = rvc_pkg::opcode_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay    <= rvc_pkg::START_DELAY_RST;
			cfg_q.low_hold_time  <= rvc_pkg::LOW_HOLD_TIME_RST;
			cfg_q.ok_hold_time   <= rvc_pkg::OK_HOLD_TIME_RST;
			cfg_q.refill_timeout <= rvc_pkg::REFILL_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rvc_pkg::CFG_START_DELAY:    cfg_q.start_delay    <= cfg_data;
				rvc_pkg::CFG_LOW_HOLD_TIME:  cfg_q.low_hold_time  <= cfg_data;
				rvc_pkg::CFG_OK_HOLD_TIME:   cfg_q.ok_hold_time   <= cfg_data;
				rvc_pkg::CFG_REFILL_TIMEOUT: cfg_q.refill_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	rvc_next u_next (
		.cfg      (cfg_q),
		.cur      (state_q),
		.opcode   (in_opcode),
		.now_ms   (s_tdata[31:0]),
		.level_ok (s_tdata[32]),
		.fault_in (s_tdata[33]),
		.nxt      (state_nxt),
		.changed  (changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= rvc_pkg::MODE_UNKNOWN;
			state_q.entered_at   <= '0;
			state_q.stable_since <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_mode_q    <= state_nxt.mode;
			out_changed_q <= changed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_changed_q, out_mode_q};

	`RVC_ASSERT_NXT(a_result_matches_state, accept,
		out_mode_q == state_q.mode, "result mode differs from stored mode")
	`RVC_ASSERT_NXT(a_changed_flag, accept,
		out_changed_q == (state_q.mode != $past(state_q.mode)), "mode_changed flag is wrong")
	`RVC_ASSERT_NXT(a_error_latches,
		state_q.mode == rvc_pkg::MODE_ERROR && !(accept && in_opcode == rvc_pkg::OP_REINIT),
		state_q.mode == rvc_pkg::MODE_ERROR, "error mode left without reinit")
	`RVC_ASSERT_IMP(a_stable_cleared_on_entry,
		state_q.mode != $past(state_q.mode) &&
		(state_q.mode == rvc_pkg::MODE_IDLE || state_q.mode == rvc_pkg::MODE_ACTIVE),
		state_q.stable_since == '0, "stable mark not cleared on entry")

endmodule

>>> sv/rvc_next.sv
// Next-state logic of the refill valve controller for one item.
// Depends on rvc_pkg for the mode, state and configuration types.
`timescale 1ns / 1ps

module rvc_next (
	input  rvc_pkg::cfg_t              cfg,
	input  rvc_pkg::state_t            cur,
	input  rvc_pkg::opcode_t           opcode,
	input  logic [rvc_pkg::TimeW-1:0]  now_ms,
	input  logic                       level_ok,
	input  logic                       fault_in,
	output rvc_pkg::state_t            nxt,
	output logic                       changed
);

	logic [rvc_pkg::TimeW-1:0] since_entry;
	logic [rvc_pkg::TimeW-1:0] stable_mark;
	logic [rvc_pkg::TimeW-1:0] since_stable;
	logic                      delay_done;
	logic                      timed_out;
	logic                      low_held;
	logic                      ok_held;
	rvc_pkg::mode_t            settle_mode;

	// An unset mark (zero) is replaced by the current time, as the hold starts now.
	assign stable_mark  = (cur.stable_since == '0) ? now_ms : cur.stable_since;
	assign since_entry  = now_ms - cur.entered_at;
	assign since_stable = now_ms - stable_mark;
	assign delay_done   = since_entry > {8'd0, cfg.start_delay};
	assign timed_out    = since_entry > {8'd0, cfg.refill_timeout};
	assign low_held     = since_stable > {8'd0, cfg.low_hold_time};
	assign ok_held      = since_stable > {8'd0, cfg.ok_hold_time};
	assign settle_mode  = level_ok ? rvc_pkg::MODE_IDLE : rvc_pkg::MODE_ACTIVE;

	always_comb begin
		nxt = cur;
		if (opcode == rvc_pkg::OP_REINIT) begin
			nxt.mode       = rvc_pkg::MODE_UNKNOWN;
			nxt.entered_at = now_ms;
		end else begin
			case (cur.mode)
				rvc_pkg::MODE_UNKNOWN: begin
					nxt.entered_at = now_ms;
					if (cfg.start_delay == '0) begin
						nxt.mode         = settle_mode;
						nxt.stable_since = '0;
					end else begin
						nxt.mode = rvc_pkg::MODE_STARTING;
					end
				end
				rvc_pkg::MODE_STARTING: begin
					if (delay_done) begin
						nxt.mode         = settle_mode;
						nxt.entered_at   = now_ms;
						nxt.stable_since = '0;
					end
				end
				rvc_pkg::MODE_IDLE: begin
					if (fault_in) begin
						nxt.mode       = rvc_pkg::MODE_ERROR;
						nxt.entered_at = now_ms;
					end else if (level_ok) begin
						nxt.stable_since = '0;
					end else if (low_held) begin
						nxt.mode         = rvc_pkg::MODE_ACTIVE;
						nxt.entered_at   = now_ms;
						nxt.stable_since = '0;
					end else begin
						nxt.stable_since = stable_mark;
					end
				end
				rvc_pkg::MODE_ACTIVE: begin
					if (fault_in || timed_out) begin
						nxt.mode       = rvc_pkg::MODE_ERROR;
						nxt.entered_at = now_ms;
					end else if (!level_ok) begin
						nxt.stable_since = '0;
					end else if (ok_held) begin
						nxt.mode         = rvc_pkg::MODE_IDLE;
						nxt.entered_at   = now_ms;
						nxt.stable_since = '0;
					end else begin
						nxt.stable_since = stable_mark;
					end
				end
				default: begin
					// Error latches until a reinit item arrives.
				end
			endcase
		end
	end

	assign changed = nxt.mode != cur.mode;

endmodule
